>>> design/rfam_pkg.sv
// Shared types, mode codes and constant tables for the recursive filter and
// AM modulator. No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rfam_pkg;

  // Operating modes. Codes above MODE_ALLPASS behave as allpass.
  typedef enum logic [2:0] {
    MODE_LOWPASS  = 3'd0,
    MODE_HIGHPASS = 3'd1,
    MODE_BANDPASS = 3'd2,
    MODE_MODULATE = 3'd3,
    MODE_ALLPASS  = 3'd4
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_SETTING = 2'd1
  } reg_index_t;

  localparam int SAMPLE_W     = 10;
  localparam int LEVEL_W      = 8;
  localparam int DATA_W       = 16;
  localparam int HIST_DEPTH   = 7;
  localparam int SINE_STEPS   = 32;
  localparam int PHASE_W      = $clog2(SINE_STEPS);
  localparam int CARRIER_SPLIT = 108;

  typedef logic signed [7:0] coef_t;
  typedef logic [HIST_DEPTH-1:0][DATA_W-1:0] hist_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [DATA_W-1:0]  feedback;
  } filt_res_t;

  // Three-tap symmetric rows: 0..7 lowpass, 8..15 highpass.
  localparam coef_t TAP3_ROWS [0:15][0:2] = '{
    '{ 8'sd8,   8'sd1,   8'sd1  }, '{ 8'sd8,   8'sd2,   8'sd2  },
    '{ 8'sd5,   8'sd11,  8'sd7  }, '{ 8'sd0,   8'sd12,  8'sd12 },
    '{-8'sd4,   8'sd10,  8'sd17 }, '{-8'sd9,   8'sd8,   8'sd17 },
    '{-8'sd6,  -8'sd5,   8'sd20 }, '{-8'sd3,  -8'sd9,  -8'sd21 },
    '{-8'sd4,  -8'sd12, -8'sd18 }, '{ 8'sd2,  -8'sd10, -8'sd21 },
    '{ 8'sd4,  -8'sd8,  -8'sd20 }, '{ 8'sd5,  -8'sd6,  -8'sd20 },
    '{ 8'sd8,   8'sd0,  -8'sd18 }, '{ 8'sd4,   8'sd10, -8'sd18 },
    '{ 8'sd1,   8'sd12, -8'sd12 }, '{-8'sd8,   8'sd2,  -8'sd3  }
  };

  // Four-tap band-pass rows.
  localparam coef_t TAP4_ROWS [0:7][0:3] = '{
    '{-8'sd5, -8'sd7,  8'sd0,  8'sd8 }, '{-8'sd1, -8'sd8, -8'sd3,  8'sd8 },
    '{ 8'sd3, -8'sd6, -8'sd6,  8'sd7 }, '{ 8'sd6, -8'sd3, -8'sd8,  8'sd6 },
    '{ 8'sd5,  8'sd1, -8'sd9,  8'sd6 }, '{-8'sd1, -8'sd8, -8'sd4,  8'sd11},
    '{ 8'sd2, -8'sd7, -8'sd7,  8'sd10}, '{ 8'sd3,  8'sd1, -8'sd11, 8'sd8 }
  };

  // One carrier period, offset binary about 128.
  localparam logic [7:0] SINE_TABLE [0:SINE_STEPS-1] = '{
    8'd128, 8'd152, 8'd176, 8'd198, 8'd217, 8'd233, 8'd245, 8'd252,
    8'd254, 8'd252, 8'd245, 8'd233, 8'd217, 8'd198, 8'd176, 8'd152,
    8'd127, 8'd103, 8'd79,  8'd57,  8'd38,  8'd22,  8'd10,  8'd3,
    8'd1,   8'd3,   8'd10,  8'd22,  8'd38,  8'd57,  8'd79,  8'd103
  };

endpackage

>>> design/rfam_filter.sv
// Recursive filter datapath: coefficient row lookup, four 8x16 wrapping
// products, sum, output level and new feedback value. Uses rfam_pkg.
`timescale 1ns / 1ps

module rfam_filter (
  input  rfam_pkg::mode_t                mode,
  input  logic [2:0]                     row,
  input  rfam_pkg::hist_t                history,
  input  logic [rfam_pkg::DATA_W-1:0]    feedback,
  output rfam_pkg::filt_res_t            result
);

  always_comb begin
    rfam_pkg::coef_t c0, c1, c2, c3;
    logic [15:0] op0, op1, op2, op3;
    logic [15:0] p0, p1, p2, p3;
    logic [15:0] acc;
    logic [15:0] u;

    case (mode)
      rfam_pkg::MODE_HIGHPASS: begin
        c0  = rfam_pkg::TAP3_ROWS[{1'b1, row}][0];
        c1  = rfam_pkg::TAP3_ROWS[{1'b1, row}][1];
        c2  = rfam_pkg::TAP3_ROWS[{1'b1, row}][2];
        c3  = 8'sd0;
        op0 = history[4] - feedback;
        op1 = history[3] - history[0];
        op2 = history[2] - history[1];
        op3 = 16'd0;
      end
      rfam_pkg::MODE_BANDPASS: begin
        c0  = rfam_pkg::TAP4_ROWS[row][0];
        c1  = rfam_pkg::TAP4_ROWS[row][1];
        c2  = rfam_pkg::TAP4_ROWS[row][2];
        c3  = rfam_pkg::TAP4_ROWS[row][3];
        op0 = history[6] + feedback;
        op1 = history[5] + history[0];
        op2 = history[4] + history[1];
        op3 = history[3] + history[2];
      end
      default: begin
        c0  = rfam_pkg::TAP3_ROWS[{1'b0, row}][0];
        c1  = rfam_pkg::TAP3_ROWS[{1'b0, row}][1];
        c2  = rfam_pkg::TAP3_ROWS[{1'b0, row}][2];
        c3  = 8'sd0;
        op0 = history[4] + feedback;
        op1 = history[3] + history[0];
        op2 = history[2] + history[1];
        op3 = 16'd0;
      end
    endcase

    // Only the low 16 bits of each product matter, so the sign-extended
    // coefficient times the operand, cut to 16 bits, is exact.
    p0  = 16'({{8{c0[7]}}, c0} * op0);
    p1  = 16'({{8{c1[7]}}, c1} * op1);
    p2  = 16'({{8{c2[7]}}, c2} * op2);
    p3  = 16'({{8{c3[7]}}, c3} * op3);
    acc = p0 + p1 + p2 + p3;
    u   = acc + 16'h8000;

    result.level    = u[15:8];
    result.feedback = {6'd0, u[15:6]} - 16'd512;
  end

endmodule

>>> design/rfam_am.sv
// Amplitude modulator: the sample's top 8 bits about 128 times a sine
// carrier about 128, scaled by 7 or 8 bits. Uses rfam_pkg.
`timescale 1ns / 1ps

module rfam_am (
  input  logic [rfam_pkg::SAMPLE_W-1:0] sample,
  input  logic [rfam_pkg::PHASE_W-1:0]  phase,
  input  logic [rfam_pkg::SAMPLE_W-1:0] setting,
  output logic [rfam_pkg::LEVEL_W-1:0]  level
);

  logic signed [8:0]  amp;
  logic signed [8:0]  carrier;
  logic signed [17:0] prod;
  logic signed [17:0] biased;

  assign amp     = $signed({1'b0, sample[9:2]}) - 9'sd128;
  assign carrier = $signed({1'b0, rfam_pkg::SINE_TABLE[phase]}) - 9'sd128;
  assign prod    = 18'(amp * carrier);
  // The biased product always lies in 0..32767, so plain bit slices serve.
  assign biased  = prod + 18'sd16384;

  always_comb begin
    if (setting > 10'(rfam_pkg::CARRIER_SPLIT)) begin
      level = biased[15:8];
    end else begin
      level = biased[14:7];
    end
  end

endmodule

>>> design/recursive_filter_and_am_modulator.sv
// Top level of the recursive filter and AM modulator: handshakes, state
// registers and output selection. Uses rfam_pkg, rfam_filter and rfam_am.
`timescale 1ns / 1ps

//  Channel   Signals                                   Direction  Beat
//  --------  ----------------------------------------  ---------  ---------------
//  sample    sample_valid, sample_ready, sample[9:0]   in         one ADC sample
//  level     level_valid, level_ready, level[7:0]      out        one output level
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in         one register write
//
// A sample beat lands in the input register; when the output register is
// free it is worked on against the filter history and feedback and the
// result goes to the output register. One sample is accepted every cycle
// as long as the output side keeps taking levels; a stalled output register
// holds its level and the input register backs up behind it. Reset (rst,
// synchronous) empties both registers, clears mode and setting, and sets
// the history to its start value. Configuration beats are always taken;
// each write to mode or setting restarts the filter history, feedback and
// carrier phase.

module recursive_filter_and_am_modulator (
  input  logic                             clk,
  input  logic                             rst,

  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  logic [rfam_pkg::SAMPLE_W-1:0]    sample,

  output logic                             level_valid,
  input  logic                             level_ready,
  output logic [rfam_pkg::LEVEL_W-1:0]     level,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [rfam_pkg::SAMPLE_W-1:0]    cfg_data
);

  // Configuration registers.
  rfam_pkg::mode_t                   mode;
  logic [rfam_pkg::SAMPLE_W-1:0]     setting;

  // Filter and modulator state.
  logic [rfam_pkg::DATA_W-1:0]       feedback;
  rfam_pkg::hist_t                   history;
  logic [rfam_pkg::PHASE_W-1:0]      phase;

  // Input register.
  logic                              in_valid;
  logic [rfam_pkg::SAMPLE_W-1:0]     in_sample;

  logic                              advance;
  logic                              cfg_we;
  logic                              cfg_hit;
  logic                              filter_mode;
  rfam_pkg::filt_res_t               filt;
  logic [rfam_pkg::LEVEL_W-1:0]      am_level;
  logic [rfam_pkg::LEVEL_W-1:0]      level_next;
  logic [rfam_pkg::PHASE_W-1:0]      phase_next;

  // The held sample moves on when the output register is empty or its level
  // is being taken in this cycle.
  assign advance      = in_valid && (!level_valid || level_ready);
  assign sample_ready = !in_valid || advance;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_we && (cfg_index == rfam_pkg::REG_MODE ||
                                cfg_index == rfam_pkg::REG_SETTING);

  assign filter_mode = (mode == rfam_pkg::MODE_LOWPASS)  ||
                       (mode == rfam_pkg::MODE_HIGHPASS) ||
                       (mode == rfam_pkg::MODE_BANDPASS);

  rfam_filter u_filter (
    .mode     (mode),
    .row      (setting[2:0]),
    .history  (history),
    .feedback (feedback),
    .result   (filt)
  );

  rfam_am u_am (
    .sample  (in_sample),
    .phase   (phase),
    .setting (setting),
    .level   (am_level)
  );

  // Result selection. Unused mode codes pass the sample through like allpass.
  always_comb begin
    case (mode)
      rfam_pkg::MODE_LOWPASS,
      rfam_pkg::MODE_HIGHPASS,
      rfam_pkg::MODE_BANDPASS: level_next = filt.level;
      rfam_pkg::MODE_MODULATE: level_next = am_level;
      default:                 level_next = in_sample[9:2];
    endcase
  end

  assign phase_next = (phase == rfam_pkg::PHASE_W'(rfam_pkg::SINE_STEPS - 1)) ?
                      '0 : phase + 1'b1;

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= rfam_pkg::MODE_LOWPASS;
      setting     <= '0;
      feedback    <= '0;
      history     <= rfam_pkg::hist_t'(1);
      phase       <= '0;
      in_valid    <= 1'b0;
      level_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        level_valid <= 1'b1;
      end else if (level_ready) begin
        level_valid <= 1'b0;
      end

      // A register write restarts the signal path. Writes must come only while the
      // block is idle; the block does not enforce it and gives a write priority.
      if (cfg_hit) begin
        if (cfg_index == rfam_pkg::REG_MODE) begin
          mode <= rfam_pkg::mode_t'(cfg_data[2:0]);
        end else begin
          setting <= cfg_data;
        end
        feedback <= '0;
        history  <= rfam_pkg::hist_t'(1);
        phase    <= '0;
      end else if (advance) begin
        history <= {history[rfam_pkg::HIST_DEPTH-2:0],
                    {6'd0, in_sample} - 16'd512};
        if (filter_mode) begin
          feedback <= filt.feedback;
        end
        if (mode == rfam_pkg::MODE_MODULATE) begin
          phase <= phase_next;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      in_sample <= sample;
    end
    if (advance) begin
      level <= level_next;
    end
  end

  // A write to mode or setting puts the filter history back to its start value and clears feedback and phase.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (feedback == '0) && (phase == '0) &&
                (history == rfam_pkg::hist_t'(1)))
    else $error("configuration write did not clear the filter state");

  // The carrier phase moves only on a modulation item or a mode or setting write.
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    (!cfg_hit && !(advance && mode == rfam_pkg::MODE_MODULATE)) |=> $stable(phase))
    else $error("carrier phase changed without a modulation item");

  // Each processed item shifts the history by one place unless a register write takes priority.
  a_hist_shift: assert property (@(posedge clk) disable iff (rst)
    (advance && !cfg_hit) |=> history[1] == $past(history[0]))
    else $error("history did not shift on a processed item");

  // A processed item always leaves a level in the output register.
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> level_valid)
    else $error("processed item produced no level");

  // Allpass passes the sample's top bits straight through.
  a_allpass: assert property (@(posedge clk) disable iff (rst)
    (advance && mode == rfam_pkg::MODE_ALLPASS) |=> level == $past(in_sample[9:2]))
    else $error("allpass level differs from the sample");

endmodule

>>> tb/sv/recursive_filter_and_am_modulator_tb.sv
// Self-checking testbench for recursive_filter_and_am_modulator: directed and random
// sample beats and register writes, checked against a behavioral predictor.
// Depends on rfam_pkg and the block's RTL only.
`timescale 1ns / 1ps

module recursive_filter_and_am_modulator_tb;
  import rfam_pkg::*;

  // Register indexes that decode to nothing; writes to them must leave all state alone.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  // Unused mode codes, which the block treats as allpass.
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int ITEM_TARGET  = 1600;
  localparam int MAX_GAP      = 12;
  localparam int DRAIN_CYCLES = 4;       // margin after the queues are empty
  localparam int LONG_STALL   = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int AM_BIAS      = 16384;   // offset added to the AM product before scaling

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                sample_valid = 1'b0;
  logic                sample_ready;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                level_valid;
  logic                level_ready = 1'b0;
  logic [LEVEL_W-1:0]  level;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [SAMPLE_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  recursive_filter_and_am_modulator dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .level_valid  (level_valid),
    .level_ready  (level_ready),
    .level        (level),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // One pending sample beat and the idle cycles the sender spends before offering it.
  typedef struct {
    logic [SAMPLE_W-1:0] value;
    int                  gap;
  } sample_item_t;

  sample_item_t       pending_samples[$];
  logic [LEVEL_W-1:0] expected_levels[$];
  int                 samples_offered = 0;   // beats taken off the pending queue
  int                 samples_accepted = 0;
  int                 levels_seen = 0;
  int                 mismatches = 0;
  bit                 quiet_stretch = 1'b0;  // when set, neither side idles
  logic               recv_hold = 1'b0;      // long receiver hold-off

  // Predictor state: a private copy of the block's registers and filter memory.
  logic [2:0]          model_mode;
  logic [SAMPLE_W-1:0] model_setting;
  logic [DATA_W-1:0]   model_fb;
  logic [DATA_W-1:0]   model_hist [HIST_DEPTH];
  logic [PHASE_W-1:0]  model_phase;

  function automatic int draw_gap();
    if (quiet_stretch || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Any write to mode or setting restarts the filter memory and the carrier phase.
  // The newest history slot starts at one, not zero.
  function automatic void clear_filter_memory();
    model_fb = '0;
    foreach (model_hist[i]) begin
      model_hist[i] = '0;
    end
    model_hist[0] = 16'd1;
    model_phase = '0;
  endfunction

  function automatic void apply_reg_write(logic [1:0] idx, logic [SAMPLE_W-1:0] data);
    if (idx == REG_MODE) begin
      model_mode = data[2:0];
      clear_filter_memory();
    end else if (idx == REG_SETTING) begin
      model_setting = data;
      clear_filter_memory();
    end
  endfunction

  function automatic logic [DATA_W-1:0] widen_coef(coef_t c);
    return {{8{c[7]}}, c};
  endfunction

  // Works out the level for one sample and advances the predictor state. Filter modes
  // use only the stored history, so their output lags the input by one sample; all
  // arithmetic there wraps at 16 bits.
  function automatic logic [LEVEL_W-1:0] predict_level(logic [SAMPLE_W-1:0] s);
    logic [DATA_W-1:0]  acc;
    logic [DATA_W-1:0]  biased;
    logic [2:0]         row;
    logic [LEVEL_W-1:0] lvl;
    bit                 filtered;
    int                 prod;
    int                 scaled;
    row = model_setting[2:0];
    acc = '0;
    filtered = 1'b1;
    case (model_mode)
      MODE_LOWPASS: begin
        acc = widen_coef(TAP3_ROWS[{1'b0, row}][0]) * (model_hist[4] + model_fb)
            + widen_coef(TAP3_ROWS[{1'b0, row}][1]) * (model_hist[3] + model_hist[0])
            + widen_coef(TAP3_ROWS[{1'b0, row}][2]) * (model_hist[2] + model_hist[1]);
      end
      MODE_HIGHPASS: begin
        // The highpass rows sit in the upper half of the three-tap table.
        acc = widen_coef(TAP3_ROWS[{1'b1, row}][0]) * (model_hist[4] - model_fb)
            + widen_coef(TAP3_ROWS[{1'b1, row}][1]) * (model_hist[3] - model_hist[0])
            + widen_coef(TAP3_ROWS[{1'b1, row}][2]) * (model_hist[2] - model_hist[1]);
      end
      MODE_BANDPASS: begin
        acc = widen_coef(TAP4_ROWS[row][0]) * (model_hist[6] + model_fb)
            + widen_coef(TAP4_ROWS[row][1]) * (model_hist[5] + model_hist[0])
            + widen_coef(TAP4_ROWS[row][2]) * (model_hist[4] + model_hist[1])
            + widen_coef(TAP4_ROWS[row][3]) * (model_hist[3] + model_hist[2]);
      end
      MODE_MODULATE: begin
        filtered = 1'b0;
        prod = (int'(s[9:2]) - 128) * (int'(SINE_TABLE[model_phase]) - 128);
        if (model_setting > CARRIER_SPLIT) begin
          scaled = (prod + AM_BIAS) >>> 8;
        end else begin
          scaled = (prod + AM_BIAS) >>> 7;
        end
        lvl = scaled[7:0];
        model_phase = model_phase + 1'b1;  // wraps after SINE_STEPS
      end
      default: begin
        // Allpass, and the unused codes that behave like it.
        filtered = 1'b0;
        lvl = s[9:2];
      end
    endcase
    if (filtered) begin
      biased = acc + 16'h8000;
      model_fb = (biased >> 6) - 16'd512;
      lvl = biased[15:8];
    end
    for (int i = HIST_DEPTH - 1; i > 0; i--) begin
      model_hist[i] = model_hist[i-1];
    end
    model_hist[0] = {6'b0, s} - 16'd512;
    return lvl;
  endfunction

  // Prints one line for each mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_sample(input logic [SAMPLE_W-1:0] v);
    sample_item_t it;
    it.value = v;
    it.gap = draw_gap();
    pending_samples.push_back(it);
  endtask

  // Returns once nothing is queued, on the wire, or awaited, plus a few cycles so the
  // block's pipeline is certainly empty. A beat counts as awaited from the moment the
  // driver takes it off the queue. Always ends just after a rising edge.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || sample_valid || expected_levels.size() != 0 ||
           levels_seen < samples_offered) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle, so the predictor can take the
  // write at its handshake without racing any sample beat.
  task automatic write_reg(input logic [1:0] idx, input logic [SAMPLE_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    apply_reg_write(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // Sample driver. Each beat is predicted at its handshake; after that the head of the
  // pending queue is offered once its own idle gap has run out. The valid level is
  // computed first and assigned once, so a back-to-back beat never drops valid.
  int lead_gap = -1;

  always @(posedge clk) begin : drive_samples
    logic         next_valid;
    sample_item_t head;
    next_valid = sample_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (sample_valid && sample_ready) begin
        expected_levels.push_back(predict_level(sample));
        samples_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_samples.size() != 0) begin
        if (lead_gap < 0) begin
          lead_gap = pending_samples[0].gap;
        end
        if (lead_gap > 0) begin
          lead_gap--;
        end else begin
          head = pending_samples.pop_front();
          samples_offered++;
          sample <= head.value;
          next_valid = 1'b1;
          lead_gap = -1;
        end
      end
    end
    sample_valid <= next_valid;
  end

  // Level monitor. Every accepted beat is matched against the oldest expectation; after
  // each beat the receiver draws how long it holds ready low.
  int ready_wait = 0;

  always @(posedge clk) begin : watch_levels
    logic [LEVEL_W-1:0] want;
    if (rst) begin
      level_ready <= 1'b0;
      ready_wait = 0;
    end else begin
      if (level_valid && level_ready) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("level beat %0d = %0d arrived with none expected",
                                    levels_seen, level));
        end else begin
          want = expected_levels.pop_front();
          if (level !== want) begin
            report_mismatch($sformatf("level beat %0d: got %0d, expected %0d",
                                      levels_seen, level, want));
          end
        end
        levels_seen++;
        ready_wait = draw_gap();
      end else if (ready_wait > 0) begin
        ready_wait--;
      end
      level_ready <= (ready_wait == 0) && !recv_hold;
    end
  end

  // One long receiver hold-off in mid run: the output register fills, the input
  // register backs up behind it and sample_ready must drop while beats keep coming.
  // It starts only with enough beats queued that the sender keeps offering.
  initial begin : long_hold
    wait (rst == 1'b0 && samples_accepted >= 300 && pending_samples.size() >= 8);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    recv_hold <= 1'b0;
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TIMEOUT after %0d cycles, %0d levels still expected", cycles,
             expected_levels.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int                  issued;
    int                  burst;
    int                  pick;
    logic [2:0]          mode_code;
    logic [SAMPLE_W-1:0] setting_val;
    model_mode = MODE_LOWPASS;
    model_setting = '0;
    clear_filter_memory();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Straight out of reset: lowpass, row zero, with the one in the newest history
    // slot feeding the first outputs.
    queue_sample(10'd0); queue_sample(10'd1023); queue_sample(10'd512);
    queue_sample(10'd511); queue_sample(10'd1023);

    // Highpass on the last row; the upper setting bits must be ignored.
    write_reg(REG_MODE, 10'(MODE_HIGHPASS));
    write_reg(REG_SETTING, 10'h3FF);
    queue_sample(10'd1023); queue_sample(10'd0); queue_sample(10'd0);

    write_reg(REG_MODE, 10'(MODE_BANDPASS));
    write_reg(REG_SETTING, 10'd5);
    queue_sample(10'd0); queue_sample(10'd1023); queue_sample(10'd0); queue_sample(10'd1023);

    // Modulation on both sides of the carrier split, with full-scale samples.
    write_reg(REG_MODE, 10'(MODE_MODULATE));
    write_reg(REG_SETTING, 10'(CARRIER_SPLIT));
    queue_sample(10'd0); queue_sample(10'd1023); queue_sample(10'd3); queue_sample(10'd1020);
    write_reg(REG_SETTING, 10'(CARRIER_SPLIT + 1));
    queue_sample(10'd0); queue_sample(10'd1023);

    // Writes to undecoded indexes must not restart the carrier phase.
    write_reg(REG_SPARE_A, 10'h3FF);
    write_reg(REG_SPARE_B, 10'h000);
    queue_sample(10'd512); queue_sample(10'd1023);

    write_reg(REG_MODE, 10'(MODE_ALLPASS));
    queue_sample(10'd0); queue_sample(10'd1023); queue_sample(10'd3);

    // All data bits set selects an unused mode code, which falls back to allpass.
    write_reg(REG_MODE, 10'h3FF);
    queue_sample(10'd1023); queue_sample(10'd0);

    // Random phases: a fresh configuration, then a burst of 10 to 80 samples that
    // lets the filters ring and, when longer than a carrier period, the phase wrap.
    issued = 0;
    while (issued < ITEM_TARGET) begin
      quiet_stretch = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 11);
      if (pick < 10) begin
        mode_code = 3'(pick % 5);
      end else begin
        mode_code = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      end
      case ($urandom_range(0, 5))
        0: setting_val = '0;
        1: setting_val = '1;
        2: setting_val = 10'(CARRIER_SPLIT);
        3: setting_val = 10'(CARRIER_SPLIT + 1);
        default: setting_val = 10'($urandom_range(0, 1023));
      endcase
      pick = $urandom_range(0, 3);
      if (pick != 1) begin
        write_reg(REG_MODE, {7'($urandom_range(0, 127)), mode_code});
      end
      if (pick != 0) begin
        write_reg(REG_SETTING, setting_val);
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  10'($urandom_range(0, 1023)));
      end
      burst = $urandom_range(10, 80);
      repeat (burst) begin
        if ($urandom_range(0, 7) == 0) begin
          queue_sample($urandom_range(0, 1) ? 10'h3FF : 10'h000);
        end else begin
          queue_sample(10'($urandom_range(0, 1023)));
        end
      end
      issued += burst;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/rfam_pkg.sv
design/rfam_filter.sv
design/rfam_am.sv
design/recursive_filter_and_am_modulator.sv
tb/sv/recursive_filter_and_am_modulator_tb.sv
